[rtl/rpc_port_mapping_table_defines.svh]
// ----------------------------------------------------------------------------
// rpc_port_mapping_table_defines
// assertion macros used by the port mapping table checker
// ----------------------------------------------------------------------------
`ifndef RPC_PORT_MAPPING_TABLE_DEFINES_SVH
`define RPC_PORT_MAPPING_TABLE_DEFINES_SVH

// property checked on every rising edge outside reset
`define RPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define RPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rpm_pkg.sv]
// ----------------------------------------------------------------------------
// rpm_pkg
// types and constants of the rpc port mapping table
// ----------------------------------------------------------------------------
package rpm_pkg;

  // table size and slot index width
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  // fixed values of the protocol
  localparam logic [31:0] LOOPBACK_ADDR = 32'h0100_007F;
  localparam logic [31:0] LOW_START     = 32'd100;

  // operation codes
  typedef enum logic [1:0] {
    KIND_SET     = 2'd0,
    KIND_UNSET   = 2'd1,
    KIND_GETPORT = 2'd2,
    KIND_QUERY   = 2'd3
  } rpm_kind_t;

  // query status codes
  typedef enum logic [1:0] {
    ST_HANDLED  = 2'd0,
    ST_UNAVAIL  = 2'd1,
    ST_MISMATCH = 2'd2
  } rpm_status_t;

  // input beat
  typedef struct packed {
    rpm_kind_t   kind;
    logic [31:0] source_addr;
    logic        internal_reg;
    logic [31:0] program_req;
    logic [31:0] version;
    logic [7:0]  protocol;
    logic [15:0] port_in;
  } rpm_in_t;

  // result beat
  typedef struct packed {
    logic        accepted;
    logic [15:0] port_out;
    logic [1:0]  query_status;
    logic [31:0] version_high;
    logic [31:0] version_low;
  } rpm_out_t;

  // one table slot
  typedef struct packed {
    logic        valid;
    logic [31:0] prog;
    logic [31:0] version;
    logic [7:0]  protocol;
    logic [15:0] port;
    logic        handler;
  } rpm_entry_t;

  // summary gathered by the scan unit over one pass
  typedef struct packed {
    logic             allowed;
    logic             dup;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic             unset_hit;
    logic [15:0]      port;
    logic             prog_seen;
    logic             handled;
    logic [31:0]      hi;
    logic [31:0]      lo;
  } rpm_scan_t;

endpackage

[rtl/rpm_cell.sv]
// ----------------------------------------------------------------------------
// rpm_cell
// one slot of the table ring: shifts from its neighbor or loads a new entry
// ----------------------------------------------------------------------------
module rpm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  rpm_pkg::rpm_entry_t shift_in,
  input  logic               load_en,
  input  rpm_pkg::rpm_entry_t load_in,
  output rpm_pkg::rpm_entry_t entry
);
  import rpm_pkg::*;

  logic       valid_r;
  rpm_entry_t data_r;

  // valid flag, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= load_in.valid;
    end else if (shift_en) begin
      valid_r <= shift_in.valid;
    end
  end

  // slot contents, meaningful only while valid
  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_in;
    end else if (shift_en) begin
      data_r <= shift_in;
    end
  end

  always_comb begin
    entry       = data_r;
    entry.valid = valid_r;
  end

endmodule

[rtl/rpm_scan.sv]
// ----------------------------------------------------------------------------
// rpm_scan
// looks at the head slot of the ring each cycle and accumulates the result
// ----------------------------------------------------------------------------
module rpm_scan (
  input  logic                     clk,
  input  logic                     init,
  input  logic                     step,
  input  logic [rpm_pkg::IDX_W-1:0] cnt,
  input  rpm_pkg::rpm_in_t         op,
  input  rpm_pkg::rpm_entry_t      head,
  output rpm_pkg::rpm_entry_t      head_nxt,
  output rpm_pkg::rpm_scan_t       summary
);
  import rpm_pkg::*;

  rpm_scan_t acc_r;
  rpm_scan_t acc_nxt;
  logic      allowed;
  logic      prog_eq;
  logic      vers_eq;
  logic      pv_hit;
  logic      trip_hit;
  logic      clear_head;

  // compare the head slot against the operation
  assign allowed    = op.internal_reg || (op.source_addr == LOOPBACK_ADDR);
  assign prog_eq    = head.valid && (head.prog == op.program_req);
  assign vers_eq    = head.version == op.version;
  assign pv_hit     = prog_eq && vers_eq;
  assign trip_hit   = pv_hit && (head.protocol == op.protocol);
  assign clear_head = (op.kind == KIND_UNSET) && allowed && pv_hit;

  // head goes back into the ring, dropped if an allowed unset matches it
  always_comb begin
    head_nxt = head;
    if (clear_head) begin
      head_nxt.valid = 1'b0;
    end
  end

  // accumulate over the pass, the operation register is settled once stepping
  always_comb begin
    acc_nxt = acc_r;
    if (init) begin
      acc_nxt           = '0;
      acc_nxt.lo        = LOW_START;
    end else if (step) begin
      acc_nxt.allowed = allowed;
      if (trip_hit) begin
        acc_nxt.dup  = 1'b1;
        acc_nxt.port = head.port;
      end
      if (!head.valid && !acc_r.free_seen) begin
        acc_nxt.free_seen = 1'b1;
        acc_nxt.free_idx  = cnt;
      end
      if (clear_head) begin
        acc_nxt.unset_hit = 1'b1;
      end
      if (prog_eq) begin
        acc_nxt.prog_seen = 1'b1;
        if (vers_eq && head.handler) begin
          acc_nxt.handled = 1'b1;
        end else begin
          if (head.version > acc_r.hi) begin
            acc_nxt.hi = head.version;
          end
          if (head.version < acc_r.lo) begin
            acc_nxt.lo = head.version;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign summary = acc_r;

endmodule

[rtl/rpc_port_mapping_table.sv]
// ----------------------------------------------------------------------------
// rpc_port_mapping_table
// bounded rpc port mapping table built as a rotating ring of slot cells
// ----------------------------------------------------------------------------
//  channel  ports                        handshake
//  input    start, busy, in_item         beat taken when start && !busy
//  result   out_valid, out_result        one-cycle strobe, no back pressure
//
//  after accept the ring rotates once past the scan unit (S_SCAN), then the free
//  slot is written and the result registered (S_DONE), then the strobe is shown.
//  busy is high from the cycle after accept until the result strobe cycle, so
//  the next beat can be taken in the strobe cycle, and never while busy.
//  synchronous active-low reset empties the table; results cannot be stalled.
// ----------------------------------------------------------------------------
module rpc_port_mapping_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rpm_pkg::rpm_in_t  in_item,
  output logic              out_valid,
  output rpm_pkg::rpm_out_t out_result
);
  import rpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cnt_r;
  rpm_in_t          op_r;
  logic             out_valid_r;
  rpm_out_t         out_r;

  logic             take;
  logic             shift_en;
  logic             set_ok;
  rpm_entry_t       ring [TABLE_DEPTH];
  rpm_entry_t       head_nxt;
  rpm_entry_t       new_entry;
  rpm_scan_t        summary;
  rpm_out_t         result;

  assign take     = start && (state_r == S_IDLE);
  assign shift_en = state_r == S_SCAN;
  assign busy     = state_r != S_IDLE;

  // scan unit on the head slot
  rpm_scan u_scan (
    .clk      (clk),
    .init     (take),
    .step     (shift_en),
    .cnt      (cnt_r),
    .op       (op_r),
    .head     (ring[0]),
    .head_nxt (head_nxt),
    .summary  (summary)
  );

  // new slot contents for a set
  always_comb begin
    new_entry          = '0;
    new_entry.valid    = 1'b1;
    new_entry.prog     = op_r.program_req;
    new_entry.version  = op_r.version;
    new_entry.protocol = op_r.protocol;
    new_entry.port     = op_r.port_in;
    new_entry.handler  = op_r.internal_reg;
  end

  assign set_ok = (op_r.kind == KIND_SET) && summary.allowed && !summary.dup &&
                  summary.free_seen;

  // ring of slot cells, head feeds back into the tail
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rpm_entry_t nb;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nb = head_nxt;
    end else begin : g_body
      assign nb = ring[i+1];
    end
    rpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .shift_in (nb),
      .load_en  ((state_r == S_DONE) && set_ok && (summary.free_idx == IDX_W'(i))),
      .load_in  (new_entry),
      .entry    (ring[i])
    );
  end

  // result fields from the pass summary
  always_comb begin
    result              = '0;
    result.version_low  = LOW_START;
    case (op_r.kind)
      KIND_SET: begin
        result.accepted = set_ok;
      end
      KIND_UNSET: begin
        result.accepted = summary.allowed && summary.unset_hit;
      end
      KIND_GETPORT: begin
        result.accepted = 1'b1;
        result.port_out = summary.port;
      end
      KIND_QUERY: begin
        result.accepted = 1'b1;
        if (summary.handled) begin
          result.query_status = ST_HANDLED;
        end else begin
          result.query_status = summary.prog_seen ? ST_MISMATCH : ST_UNAVAIL;
          result.version_high = summary.hi;
          result.version_low  = summary.lo;
        end
      end
      default: begin
        result.accepted = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_item;
            cnt_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_r       <= result;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

[rtl/rpm_checker.sv]
// ----------------------------------------------------------------------------
// rpm_checker
// port-level checks of the rpc port mapping table, bound to the top level
// ----------------------------------------------------------------------------
`include "rpc_port_mapping_table_defines.svh"

module rpm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rpm_pkg::rpm_out_t out_result,
  input logic              out_valid
);
  import rpm_pkg::*;

  logic has_status;
  logic has_port;

  // accepted beat makes the block busy
  `RPM_ASSERT(a_take_busy, start && !busy |=> busy, "accepted beat did not raise busy")

  // a result strobe lasts one cycle and shows with busy low
  `RPM_ASSERT(a_strobe_once, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `RPM_ASSERT(a_strobe_idle, out_valid |-> !busy, "result strobe while busy")

  // query status and port only come with an accepted lookup
  assign has_status = out_valid && (out_result.query_status != ST_HANDLED);
  assign has_port   = out_valid && (out_result.port_out != 16'd0);
  `RPM_ASSERT(a_status_acc, has_status |-> out_result.accepted, "query status without accepted")
  `RPM_ASSERT(a_port_only, has_port |-> out_result.accepted && !has_status, "stray port")

endmodule

bind rpc_port_mapping_table rpm_checker u_rpm_checker (.*);
